// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/nfci_pkg.sv
// ----------------------------------------------------------------------------
// nfci_pkg
// shared types and constants of the cubic newton iterator
// ----------------------------------------------------------------------------
`default_nettype none

package nfci_pkg;

  // width of the offset dividend used for the floor division by three
  localparam int unsigned D3_W = 48;
  // offset 3 * 2^44 keeps the dividend positive
  localparam logic signed [63:0] D3_OFF = 64'sh0000_3000_0000_0000;
  localparam logic signed [63:0] D3_BIAS = 64'sh0000_1000_0000_0000;

  // dividend split into two 24 bit halves, 2^24 = 3 * D3_HI + 1
  localparam int unsigned D3_LO_W = 24;
  localparam int unsigned D3_HP_W = 47;
  localparam int unsigned D3_Y_W = 25;
  localparam logic [22:0] D3_HI = 23'd5592405;
  // ceil(2^26 / 3), exact floor division by three for values below 2^25
  localparam logic [24:0] D3_RECIP = 25'd22369622;
  localparam int unsigned D3_RECIP_SH = 26;

endpackage

`default_nettype wire

// File: hw/rtl/nfci_divider.sv
// ----------------------------------------------------------------------------
// nfci_divider
// restoring unsigned divider, one quotient bit per cycle, left aligned dividend
// ----------------------------------------------------------------------------
`default_nettype none

module nfci_divider #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start_i,
  input  wire [2*FRAC_BITS+31:0]      dividend_i,
  input  wire [63:0]                  divisor_i,
  output logic                        done_o,
  output logic [2*FRAC_BITS+31:0]     quot_o
);

  localparam int unsigned DW = 2 * FRAC_BITS + 32;
  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] sh_q, sh_d;
  logic [63:0]   rem_q, rem_d;
  logic [63:0]   dvs_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [63:0]   rem2;
  logic          ge;

  assign rem2 = {rem_q[62:0], sh_q[DW-1]};
  assign ge   = rem2 >= dvs_q;

  always_comb begin
    sh_d   = sh_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      sh_d   = dividend_i;
      rem_d  = '0;
      cnt_d  = CW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      sh_d  = {sh_q[DW-2:0], ge};
      rem_d = ge ? rem2 - dvs_q : rem2;
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    if (start_i && !busy_q) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule

`default_nettype wire

// File: hw/rtl/newton_fractal_cubic_iterator_core.sv
// ----------------------------------------------------------------------------
// newton_fractal_cubic_iterator_core
// newton iteration for z^3+1 on one q4.28 start point, shared mul and divider
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// start     in         start & !busy          start_re_i, start_im_i
// result    out        valid_o (one cycle)    root_re_o, root_im_o, steps_taken_o,
//                                             converged_o, fault_o
// config    in         cfg_we_i               cfg_wdata_i (max_iterations)
//
// each newton step runs the bit-serial divider twice, computing the two parts
// of 1/z one after the other. S_FIN, and so valid_o, follows S_UPD directly
// when a step converges or faults, and follows S_CHECK when the step limit or
// a zero iterate ends the run.
// busy is high from acceptance through the valid_o cycle; results cannot stall.
// reset sets max_iterations to 20 and idles the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module newton_fractal_cubic_iterator_core #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  wire signed [31:0]  start_re_i,
  input  wire signed [31:0]  start_im_i,
  input  wire                cfg_we_i,
  input  wire [7:0]          cfg_wdata_i,
  output logic               valid_o,
  output logic signed [31:0] root_re_o,
  output logic signed [31:0] root_im_o,
  output logic [7:0]         steps_taken_o,
  output logic               converged_o,
  output logic               fault_o
);
  import nfci_pkg::*;

  localparam int unsigned DW = 2 * FRAC_BITS + 32;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_CHECK = 15'b000000000000010,
    S_SQA   = 15'b000000000000100,
    S_SQB   = 15'b000000000001000,
    S_DEN   = 15'b000000000010000,
    S_DIVR  = 15'b000000000100000,
    S_DIVI  = 15'b000000001000000,
    S_MRR   = 15'b000000010000000,
    S_MII   = 15'b000000100000000,
    S_MRI   = 15'b000001000000000,
    S_TSUM  = 15'b000010000000000,
    S_D3R   = 15'b000100000000000,
    S_D3I   = 15'b001000000000000,
    S_UPD   = 15'b010000000000000,
    S_FIN   = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  logic [7:0]         max_q;
  logic signed [31:0] a_q, b_q;
  logic [7:0]         steps_q;
  logic               conv_q, flt_q, hit_q;
  logic signed [63:0] acc_q, prod_q, d_q;
  logic signed [31:0] ur_q, ui_q, nr_q, ni_q;
  logic [D3_W-1:0]    xr_q, xi_q;
  logic [D3_HP_W-1:0] hr_q, hi_q;
  logic [D3_Y_W-1:0]  yr_q, yi_q;

  logic [31:0]        ma, mb;
  logic signed [32:0] op_x, op_y;
  logic signed [65:0] mul;
  logic               mul_en;
  logic               div_start;
  logic [DW-1:0]      div_dividend;
  logic [63:0]        div_divisor;
  logic               div_done;
  logic [DW-1:0]      quot;
  logic signed [63:0] tr, ti;
  logic [32:0]        fr, fi;
  logic               q_big, q_over;
  logic signed [31:0] u_pos, u_neg;

  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > 64'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < -64'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // floor(x / 3) - 2^44 from the split halves, saturated, flag in bit 32
  function automatic logic [32:0] div3_fin(input logic [D3_HP_W-1:0] h,
                                           input logic [D3_Y_W-1:0] y);
    logic [2*D3_Y_W-1:0] p;
    logic signed [63:0]  q;
    p = {{D3_Y_W{1'b0}}, y} * {{D3_Y_W{1'b0}}, D3_RECIP};
    q = $signed(64'(h) + 64'(p[2*D3_Y_W-1:D3_RECIP_SH])) - D3_BIAS;
    return sat32(q);
  endfunction

  assign ma = a_q[31] ? 32'(-a_q) : 32'(a_q);
  assign mb = b_q[31] ? 32'(-b_q) : 32'(b_q);

  // quotient magnitude range checks for the reciprocal
  assign q_big  = |quot[DW-1:31];
  assign q_over = (|quot[DW-1:32]) || (quot[31] && (|quot[30:0]));
  assign u_pos  = q_big ? 32'sh7fff_ffff : $signed(quot[31:0]);
  assign u_neg  = q_over ? 32'sh8000_0000 : $signed(-quot[31:0]);

  // shared multiplier operand select
  always_comb begin
    op_x   = '0;
    op_y   = '0;
    mul_en = 1'b1;
    unique case (state_q)
      S_SQA:   begin op_x = {1'b0, ma}; op_y = {1'b0, ma}; end
      S_SQB:   begin op_x = {1'b0, mb}; op_y = {1'b0, mb}; end
      S_MRR:   begin op_x = 33'(ur_q); op_y = 33'(ur_q); end
      S_MII:   begin op_x = 33'(ui_q); op_y = 33'(ui_q); end
      S_MRI:   begin op_x = 33'(ur_q); op_y = 33'(ui_q); end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul = op_x * op_y;

  // 2z - p plus offset so the division by three sees a positive value
  assign tr = ($signed(64'(a_q)) <<< 1) - (acc_q >>> FRAC_BITS) + D3_OFF;
  assign ti = ($signed(64'(b_q)) <<< 1) - (prod_q >>> (FRAC_BITS - 1)) + D3_OFF;
  assign fr = div3_fin(hr_q, yr_q);
  assign fi = div3_fin(hi_q, yi_q);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = d_q;
    unique case (state_q)
      S_DEN: begin
        div_start    = 1'b1;
        div_dividend = {ma, {(2 * FRAC_BITS){1'b0}}};
        div_divisor  = 64'(acc_q + prod_q);
      end
      S_DIVR: begin
        div_start    = div_done;
        div_dividend = {mb, {(2 * FRAC_BITS){1'b0}}};
      end
      default: ;
    endcase
  end

  nfci_divider #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (start) state_d = S_CHECK;
      S_CHECK: begin
        if (steps_q == max_q) begin
          state_d = S_FIN;
        end else if (a_q == 32'sd0 && b_q == 32'sd0) begin
          state_d = S_FIN;
        end else begin
          state_d = S_SQA;
        end
      end
      S_SQA:   state_d = S_SQB;
      S_SQB:   state_d = S_DEN;
      S_DEN:   state_d = S_DIVR;
      S_DIVR:  if (div_done) state_d = S_DIVI;
      S_DIVI:  if (div_done) state_d = S_MRR;
      S_MRR:   state_d = S_MII;
      S_MII:   state_d = S_MRI;
      S_MRI:   state_d = S_TSUM;
      S_TSUM:  state_d = S_D3R;
      S_D3R:   state_d = S_D3I;
      S_D3I:   state_d = S_UPD;
      S_UPD: begin
        if (hit_q || (nr_q == a_q && ni_q == b_q)) begin
          state_d = S_FIN;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_FIN:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      max_q   <= 8'd20;
      steps_q <= '0;
      conv_q  <= 1'b0;
      flt_q   <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            steps_q <= '0;
            conv_q  <= 1'b0;
            flt_q   <= 1'b0;
          end
        end
        S_CHECK: begin
          hit_q <= 1'b0;
          if (steps_q != max_q && a_q == 32'sd0 && b_q == 32'sd0) begin
            flt_q <= 1'b1;
          end
        end
        S_DIVR:  if (div_done && (a_q[31] ? q_over : q_big)) hit_q <= 1'b1;
        S_DIVI:  if (div_done && (b_q[31] ? q_big : q_over)) hit_q <= 1'b1;
        S_D3I:   if (fr[32] || fi[32]) hit_q <= 1'b1;
        S_UPD: begin
          steps_q <= steps_q + 8'd1;
          if (hit_q) begin
            flt_q <= 1'b1;
          end else if (nr_q == a_q && ni_q == b_q) begin
            conv_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= mul[63:0];
    end
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          a_q <= start_re_i;
          b_q <= start_im_i;
        end
      end
      S_SQB, S_MII: acc_q <= prod_q;
      S_MRI:        acc_q <= acc_q - prod_q;
      S_DEN:        d_q   <= acc_q + prod_q;
      S_DIVR:       if (div_done) ur_q <= a_q[31] ? u_neg : u_pos;
      S_DIVI:       if (div_done) ui_q <= b_q[31] ? u_pos : u_neg;
      S_TSUM: begin
        xr_q <= tr[D3_W-1:0];
        xi_q <= ti[D3_W-1:0];
      end
      // x = h * 2^24 + l, so floor(x / 3) = h * D3_HI + floor((h + l) / 3)
      S_D3R: begin
        hr_q <= D3_HP_W'(xr_q[D3_W-1:D3_LO_W]) * D3_HP_W'(D3_HI);
        hi_q <= D3_HP_W'(xi_q[D3_W-1:D3_LO_W]) * D3_HP_W'(D3_HI);
        yr_q <= D3_Y_W'(xr_q[D3_W-1:D3_LO_W]) + D3_Y_W'(xr_q[D3_LO_W-1:0]);
        yi_q <= D3_Y_W'(xi_q[D3_W-1:D3_LO_W]) + D3_Y_W'(xi_q[D3_LO_W-1:0]);
      end
      S_D3I: begin
        nr_q <= fr[31:0];
        ni_q <= fi[31:0];
      end
      S_UPD: begin
        a_q <= nr_q;
        b_q <= ni_q;
      end
      default: ;
    endcase
  end

  assign busy          = (state_q != S_IDLE);
  assign valid_o       = (state_q == S_FIN);
  assign root_re_o     = a_q;
  assign root_im_o     = b_q;
  assign steps_taken_o = steps_q;
  assign converged_o   = conv_q;
  assign fault_o       = flt_q;

  `ASSERT_NEXT(a_single_pulse, clk_i, rst_ni, valid_o, !valid_o, "result strobe longer than one cycle")
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accepted transaction did not raise busy")
  `ASSERT_ALWAYS(a_flags_excl, clk_i, rst_ni, !(valid_o && converged_o && fault_o), "converged and fault both set")
  `ASSERT_ALWAYS(a_steps_bound, clk_i, rst_ni, !valid_o || (steps_taken_o <= max_q), "steps exceed limit")

endmodule

`default_nettype wire
